// ===== sv/envnf_pkg.sv =====
// ----------------------------------------------------------------------------
// envnf_pkg
// Shared types, defaults and codes for the envelope noise floor estimator.
// ----------------------------------------------------------------------------
package envnf_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int CS_W     = 19;
    localparam int AVG_W    = 32;
    localparam int IDX_W    = 3;

    // Default ring depths
    localparam int LONG_DEPTH_DEF  = 200;
    localparam int SHORT_DEPTH_DEF = 50;

    // Reset values
    localparam logic [SAMPLE_W-1:0] ONE_Q14   = 16'd16384;
    localparam logic [AVG_W-1:0]    AVG_RESET = 32'd53687091;

    localparam logic [15:0] RATE_DEF        = 16'd262;
    localparam logic [15:0] NOISE_GAIN_DEF  = 16'd4915;
    localparam logic [15:0] NOISE_FLOOR_DEF = 16'd82;
    localparam logic [15:0] BIAS_GAIN_DEF   = 16'd39322;
    localparam logic [15:0] BIAS_OFFSET_DEF = 16'd819;
    localparam logic [15:0] OUT_GAIN_DEF    = 16'd18022;

    // Register indexes
    typedef enum logic [IDX_W-1:0] {
        CFG_AVERAGE_RATE = 3'd0,
        CFG_NOISE_GAIN   = 3'd1,
        CFG_NOISE_FLOOR  = 3'd2,
        CFG_BIAS_GAIN    = 3'd3,
        CFG_BIAS_OFFSET  = 3'd4,
        CFG_OUTPUT_GAIN  = 3'd5
    } t_cfg_idx;

    // Register file contents
    typedef struct packed {
        logic [15:0] average_rate;
        logic [15:0] noise_gain;
        logic [15:0] noise_floor;
        logic [15:0] bias_gain;
        logic [15:0] bias_offset;
        logic [15:0] output_gain;
    } t_cfg;

    // Ring control toward one ring
    typedef struct packed {
        logic shift;
        logic insert;
    } t_ring_ctl;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_LOAD  = 3'd1,
        ST_SCAN  = 3'd2,
        ST_START = 3'd3,
        ST_MATH  = 3'd4,
        ST_HOLD  = 3'd5
    } t_state;

endpackage

// ===== sv/envelope_noise_floor_estimator_unit.sv =====
// ----------------------------------------------------------------------------
// envelope_noise_floor_estimator_unit
// Minimum statistics noise floor estimator over a long and a short ring.
// Each request passes load, a full rotation of the longer cell ring, one
//   entry per cycle, then start, the six-stage math pipeline and the output
//   register. A new request is taken only after the previous result has
//   been loaded into the output register, which waits while it is full.
// Reset (synchronous, active low): rings hold 1.0, average 0.05, registers
//   at defaults; the first request after reset is not stored in the rings.
// ----------------------------------------------------------------------------
module envelope_noise_floor_estimator_unit #(
    parameter int LONG_DEPTH  = envnf_pkg::LONG_DEPTH_DEF,
    parameter int SHORT_DEPTH = envnf_pkg::SHORT_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration write port
    input  logic                        i_cfg_we,
    input  logic [envnf_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]                 i_cfg_data,
    // Input stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [15:0]                 s_axis_tdata,  // [15:0] envelope_sample
    // Output stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [39:0]                 m_axis_tdata   // [15:0] noise_power,
                                                       // [34:16] centered_sample
);

    localparam int SCAN_LEN = (LONG_DEPTH > SHORT_DEPTH) ? LONG_DEPTH : SHORT_DEPTH;
    localparam int CNT_W    = $clog2(SCAN_LEN);

    envnf_pkg::t_state              r_state, n_state;
    envnf_pkg::t_cfg                r_cfg;
    envnf_pkg::t_ring_ctl           w_long_ctl, w_short_ctl;
    logic [CNT_W-1:0]               r_cnt;
    logic                           r_first_skipped;
    logic [envnf_pkg::SAMPLE_W-1:0] r_sample;
    logic [envnf_pkg::SAMPLE_W-1:0] r_min, n_min;
    logic                           r_out_valid;
    logic [39:0]                    r_out_data;
    logic [envnf_pkg::SAMPLE_W-1:0] w_long_tail, w_short_tail;
    logic                           w_accept, w_scan_last, w_out_free, w_out_load;
    logic                           w_math_start, w_math_done;
    logic [envnf_pkg::SAMPLE_W-1:0] w_np;
    logic [envnf_pkg::CS_W-1:0]     w_cs;

    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_scan_last = (r_cnt == CNT_W'(SCAN_LEN - 1));
    assign w_out_free  = !r_out_valid || m_axis_tready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.average_rate <= envnf_pkg::RATE_DEF;
            r_cfg.noise_gain   <= envnf_pkg::NOISE_GAIN_DEF;
            r_cfg.noise_floor  <= envnf_pkg::NOISE_FLOOR_DEF;
            r_cfg.bias_gain    <= envnf_pkg::BIAS_GAIN_DEF;
            r_cfg.bias_offset  <= envnf_pkg::BIAS_OFFSET_DEF;
            r_cfg.output_gain  <= envnf_pkg::OUT_GAIN_DEF;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                envnf_pkg::CFG_AVERAGE_RATE: r_cfg.average_rate <= i_cfg_data;
                envnf_pkg::CFG_NOISE_GAIN:   r_cfg.noise_gain   <= i_cfg_data;
                envnf_pkg::CFG_NOISE_FLOOR:  r_cfg.noise_floor  <= i_cfg_data;
                envnf_pkg::CFG_BIAS_GAIN:    r_cfg.bias_gain    <= i_cfg_data;
                envnf_pkg::CFG_BIAS_OFFSET:  r_cfg.bias_offset  <= i_cfg_data;
                envnf_pkg::CFG_OUTPUT_GAIN:  r_cfg.output_gain  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            envnf_pkg::ST_IDLE:  if (w_accept) n_state = envnf_pkg::ST_LOAD;
            envnf_pkg::ST_LOAD:  n_state = envnf_pkg::ST_SCAN;
            envnf_pkg::ST_SCAN:  if (w_scan_last) n_state = envnf_pkg::ST_START;
            envnf_pkg::ST_START: n_state = envnf_pkg::ST_MATH;
            envnf_pkg::ST_MATH: begin
                if (w_math_done) begin
                    n_state = w_out_free ? envnf_pkg::ST_IDLE : envnf_pkg::ST_HOLD;
                end
            end
            envnf_pkg::ST_HOLD:  if (w_out_free) n_state = envnf_pkg::ST_IDLE;
            default:             n_state = envnf_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_axis_tready      = 1'b0;
        w_long_ctl         = '0;
        w_short_ctl        = '0;
        w_math_start       = 1'b0;
        w_out_load         = 1'b0;
        case (r_state)
            envnf_pkg::ST_IDLE: s_axis_tready = 1'b1;
            envnf_pkg::ST_LOAD: begin
                w_long_ctl.shift   = r_first_skipped;
                w_long_ctl.insert  = 1'b1;
                w_short_ctl.shift  = r_first_skipped;
                w_short_ctl.insert = 1'b1;
            end
            envnf_pkg::ST_SCAN: begin
                w_long_ctl.shift  = ({1'b0, r_cnt} < (CNT_W+1)'(LONG_DEPTH));
                w_short_ctl.shift = ({1'b0, r_cnt} < (CNT_W+1)'(SHORT_DEPTH));
            end
            envnf_pkg::ST_START: w_math_start = 1'b1;
            envnf_pkg::ST_MATH:  w_out_load = w_math_done && w_out_free;
            envnf_pkg::ST_HOLD:  w_out_load = w_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= envnf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // First-sample skip flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_skipped <= 1'b0;
        end else if (r_state == envnf_pkg::ST_LOAD) begin
            r_first_skipped <= 1'b1;
        end
    end

    // Captured sample
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample <= s_axis_tdata[15:0];
        end
    end

    // Scan counter and running minimum over both ring tails
    always_comb begin
        n_min = r_min;
        if (w_long_ctl.shift && (w_long_tail < n_min)) begin
            n_min = w_long_tail;
        end
        if (w_short_ctl.shift && (w_short_tail < n_min)) begin
            n_min = w_short_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == envnf_pkg::ST_LOAD) begin
            r_cnt <= '0;
            r_min <= '1;
        end else if (r_state == envnf_pkg::ST_SCAN) begin
            r_cnt <= r_cnt + 1'b1;
            r_min <= n_min;
        end
    end

    envnf_ring #(.DEPTH(LONG_DEPTH)) u_long_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_long_ctl),
        .i_sample (r_sample),
        .o_tail   (w_long_tail)
    );

    envnf_ring #(.DEPTH(SHORT_DEPTH)) u_short_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_short_ctl),
        .i_sample (r_sample),
        .o_tail   (w_short_tail)
    );

    envnf_math u_math (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (w_math_start),
        .i_min         (r_min),
        .i_sample      (r_sample),
        .i_cfg         (r_cfg),
        .o_done        (w_math_done),
        .o_noise_power (w_np),
        .o_centered    (w_cs)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= {5'd0, w_cs, w_np};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ===== sv/envnf_cell.sv =====
// ----------------------------------------------------------------------------
// envnf_cell
// One storage cell of a ring: takes its neighbor's value on a shift.
// ----------------------------------------------------------------------------
module envnf_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_shift,
    input  logic [envnf_pkg::SAMPLE_W-1:0] i_data,
    output logic [envnf_pkg::SAMPLE_W-1:0] o_data
);

    logic [envnf_pkg::SAMPLE_W-1:0] r_val;

    // Holds 1.0 out of reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= envnf_pkg::ONE_Q14;
        end else if (i_shift) begin
            r_val <= i_data;
        end
    end

    assign o_data = r_val;

endmodule

// ===== sv/envnf_ring.sv =====
// ----------------------------------------------------------------------------
// envnf_ring
// Chain of cells forming a ring. A shift either rotates the tail back to the
// head or inserts a new sample at the head, dropping the oldest entry.
// ----------------------------------------------------------------------------
module envnf_ring #(
    parameter int DEPTH = envnf_pkg::LONG_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  envnf_pkg::t_ring_ctl           i_ctl,
    input  logic [envnf_pkg::SAMPLE_W-1:0] i_sample,
    output logic [envnf_pkg::SAMPLE_W-1:0] o_tail
);

    logic [envnf_pkg::SAMPLE_W-1:0] w_chain [DEPTH+1];

    // Head input: new sample or recirculated tail
    assign w_chain[0] = i_ctl.insert ? i_sample : w_chain[DEPTH];

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++) begin : g_cell
            envnf_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (i_ctl.shift),
                .i_data  (w_chain[k]),
                .o_data  (w_chain[k+1])
            );
        end
    endgenerate

    assign o_tail = w_chain[DEPTH];

endmodule

// ===== sv/envnf_math.sv =====
// ----------------------------------------------------------------------------
// envnf_math
// Six-stage arithmetic pipeline: average update, noise power and centered
// sample. Holds the running average and its last results.
// ----------------------------------------------------------------------------
module envnf_math (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [envnf_pkg::SAMPLE_W-1:0] i_min,
    input  logic [envnf_pkg::SAMPLE_W-1:0] i_sample,
    input  envnf_pkg::t_cfg                i_cfg,
    output logic                           o_done,
    output logic [envnf_pkg::SAMPLE_W-1:0] o_noise_power,
    output logic [envnf_pkg::CS_W-1:0]     o_centered
);

    localparam logic signed [23:0] CS_MAX = 24'sd262143;
    localparam logic signed [23:0] CS_MIN = -24'sd262144;

    logic [5:0]                     r_vld;
    logic [48:0]                    r_p_old;
    logic [31:0]                    r_p_new;
    logic [envnf_pkg::AVG_W-1:0]    r_avg;
    logic [47:0]                    r_np_prod;
    logic [47:0]                    r_bias_prod;
    logic [envnf_pkg::SAMPLE_W-1:0] r_np;
    logic signed [36:0]             r_cen;
    logic signed [53:0]             r_z_prod;
    logic [envnf_pkg::CS_W-1:0]     r_cs;

    logic [48:0]                    w_avg_sum;
    logic [48:0]                    w_np_sum;
    logic [18:0]                    w_np_q;
    logic [envnf_pkg::SAMPLE_W-1:0] w_np_sat;
    logic [48:0]                    w_bias_sum;
    logic signed [36:0]             w_cen;
    logic signed [53:0]             w_z_sum;
    logic signed [23:0]             w_z;

    // Stage valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], i_start};
        end
    end

    // Stage 1: the two weighted products
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_p_old <= r_avg * (17'h10000 - {1'b0, i_cfg.average_rate});
            r_p_new <= i_min * i_cfg.average_rate;
        end
    end

    // Stage 2: rounded average
    assign w_avg_sum = r_p_old + {1'b0, r_p_new, 16'd0} + 49'd32768;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg <= envnf_pkg::AVG_RESET;
        end else if (r_vld[0]) begin
            r_avg <= w_avg_sum[47:16];
        end
    end

    // Stage 3: scale the average
    always_ff @(posedge i_clk) begin
        if (r_vld[1]) begin
            r_np_prod   <= r_avg * i_cfg.noise_gain;
            r_bias_prod <= r_avg * i_cfg.bias_gain;
        end
    end

    // Stage 4: noise power with saturation and floor; centered value
    assign w_np_sum   = {1'b0, r_np_prod} + 49'd536870912;
    assign w_np_q     = w_np_sum[48:30];
    assign w_np_sat   = (w_np_q > 19'd65535) ? 16'hFFFF : w_np_q[15:0];
    assign w_bias_sum = {1'b0, r_bias_prod} + 49'd8192;
    assign w_cen      = $signed({5'd0, i_sample, 16'd0})
                      - $signed({2'd0, w_bias_sum[48:14]})
                      - $signed({5'd0, i_cfg.bias_offset, 16'd0});

    always_ff @(posedge i_clk) begin
        if (r_vld[2]) begin
            r_np  <= (w_np_sat < i_cfg.noise_floor) ? i_cfg.noise_floor : w_np_sat;
            r_cen <= w_cen;
        end
    end

    // Stage 5: output gain
    always_ff @(posedge i_clk) begin
        if (r_vld[3]) begin
            r_z_prod <= r_cen * $signed({1'b0, i_cfg.output_gain});
        end
    end

    // Stage 6: round half up, saturate to the output range
    assign w_z_sum = r_z_prod + 54'sd536870912;
    assign w_z     = w_z_sum[53:30];

    always_ff @(posedge i_clk) begin
        if (r_vld[4]) begin
            if (w_z > CS_MAX) begin
                r_cs <= CS_MAX[18:0];
            end else if (w_z < CS_MIN) begin
                r_cs <= CS_MIN[18:0];
            end else begin
                r_cs <= w_z[18:0];
            end
        end
    end

    assign o_done        = r_vld[5];
    assign o_noise_power = r_np;
    assign o_centered    = r_cs;

endmodule
